FILE: design/rbe_pkg.sv
// Shared types and constants for the reconnect backoff engine.
// Depends on nothing; every other design file imports it.
package rbe_pkg;

   localparam int DELAY_BITS     = 24;
   localparam int DELAY_OUT_BITS = DELAY_BITS + 1;
   localparam int ATTEMPT_BITS   = 8;
   localparam int JITTER_BITS    = 16;
   localparam int RANDOM_BITS    = 32;
   localparam int RANDOM_CNT_BITS = $clog2(RANDOM_BITS);
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] FUNC_RESET   = 2'd0;
   localparam logic [1:0] FUNC_BUSY    = 2'd1;
   localparam logic [1:0] FUNC_REQUEST = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAP    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JITTER = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUSY   = 2'd3;

   localparam logic [DELAY_BITS-1:0]  BASE_RESET   = DELAY_BITS'(1000);
   localparam logic [DELAY_BITS-1:0]  CAP_RESET    = DELAY_BITS'(60000);
   localparam logic [JITTER_BITS-1:0] JITTER_RESET = '0;
   localparam logic [DELAY_BITS-1:0]  BUSY_RESET   = DELAY_BITS'(5000);

   localparam logic [ATTEMPT_BITS-1:0] ATTEMPT_MAX = '1;

   typedef struct packed {
      logic [1:0]             func;
      logic [RANDOM_BITS-1:0] random_value;
   } req_type;

   typedef struct packed {
      logic [DELAY_OUT_BITS-1:0] delay_ms;
      logic                      from_busy;
      logic [ATTEMPT_BITS-1:0]   attempt_index;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

endpackage

FILE: design/rbe_serial_mod.sv
// Bit-serial restoring remainder: random word modulo (jitter span + 1).
// Depends on rbe_pkg for field widths.
module rbe_serial_mod (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [rbe_pkg::RANDOM_BITS-1:0]       dividend,
   input  logic [rbe_pkg::JITTER_BITS-1:0]       span,
   output logic                                  done,
   output logic [rbe_pkg::JITTER_BITS:0]         remainder
);
   import rbe_pkg::*;

   logic                       running_ff, running_in;
   logic [RANDOM_CNT_BITS-1:0] count_ff, count_in;
   logic [RANDOM_BITS-1:0]     quo_ff, quo_in;
   logic [JITTER_BITS:0]       rem_ff, rem_in;
   logic [JITTER_BITS:0]       div_ff, div_in;
   logic [JITTER_BITS+1:0]     trial;

   always_comb begin
      running_in = running_ff;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      trial      = {rem_ff, quo_ff[RANDOM_BITS-1]};
      if (start) begin
         running_in = 1'b1;
         count_in   = RANDOM_CNT_BITS'(RANDOM_BITS - 1);
         quo_in     = dividend;
         rem_in     = '0;
         div_in     = {1'b0, span} + (JITTER_BITS+1)'(1);
      end else if (running_ff) begin
         quo_in = {quo_ff[RANDOM_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = (JITTER_BITS+1)'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[JITTER_BITS:0];
         end
         if (count_ff == '0) begin
            running_in = 1'b0;
         end else begin
            count_in = count_ff - RANDOM_CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         count_ff   <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = !running_ff;
   assign remainder = rem_ff;

   // The partial remainder stays below the divisor throughout the run.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> rem_ff < div_ff)
      else $error("partial remainder reached the divisor");

endmodule

FILE: design/reconnect_backoff_engine.sv
// Top level of the reconnect backoff engine: command port, register file,
// doubling loop and sequencer. Depends on rbe_pkg and rbe_serial_mod.
//
//   channel   ports                             direction  handshake
//   request   start, busy, req_data             in         start && !busy
//   response  rsp_strobe, rsp_data              out        one-cycle strobe
//   registers csr_we, csr_index, csr_wdata      in         write on csr_we
//
// For reset and busy notices, unused codes and a request answered from the
// busy latch, busy never rises, and a busy answer strobes in the next cycle.
// A backoff request holds busy while the serial remainder unit takes in one
// bit of the 32-bit random word per cycle; the doubling loop (at most 24
// steps, one shift and compare each) runs beside it. The response strobes
// in the same cycle that busy falls.
// Reset is synchronous; it restores the register defaults, clears the
// attempt counter and the busy latch. The receiver of responses cannot stall.
module reconnect_backoff_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rbe_pkg::req_type                     req_data,
   output logic                                 rsp_strobe,
   output rbe_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [rbe_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rbe_pkg::DELAY_BITS-1:0]       csr_wdata
);
   import rbe_pkg::*;

   // Configuration registers.
   logic [DELAY_BITS-1:0]  base_ff, cap_ff, busy_delay_ff;
   logic [JITTER_BITS-1:0] jitter_ff;

   // Sequencer and backoff state.
   state_type               state_ff, state_in;
   logic [ATTEMPT_BITS-1:0] attempt_ff, attempt_in;
   logic                    busy_latched_ff, busy_latched_in;
   logic [ATTEMPT_BITS-1:0] remain_ff, remain_in;
   logic [DELAY_BITS-1:0]   dbl_ff, dbl_in;
   logic                    clamped_ff, clamped_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    mod_start;
   logic                    mod_done;
   logic [JITTER_BITS:0]    mod_rem;
   logic [DELAY_BITS:0]     dbl_shift;
   logic                    dbl_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= BASE_RESET;
         cap_ff        <= CAP_RESET;
         jitter_ff     <= JITTER_RESET;
         busy_delay_ff <= BUSY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE:   base_ff       <= csr_wdata;
            CSR_CAP:    cap_ff        <= csr_wdata;
            CSR_JITTER: jitter_ff     <= csr_wdata[JITTER_BITS-1:0];
            CSR_BUSY:   busy_delay_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   rbe_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_data.random_value),
      .span      (jitter_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign dbl_shift = {dbl_ff, 1'b0};
   // The loop ends when the attempts are used up, the clamp hit, or the
   // value is zero and can no longer grow.
   assign dbl_done  = (remain_ff == '0) || clamped_ff || (dbl_ff == '0);

   always_comb begin
      state_in        = state_ff;
      attempt_in      = attempt_ff;
      busy_latched_in = busy_latched_ff;
      remain_in       = remain_ff;
      dbl_in          = dbl_ff;
      clamped_in      = clamped_ff;
      rsp_strobe_in   = 1'b0;
      rsp_data_in     = rsp_data_ff;
      mod_start       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.func)
                  FUNC_RESET: attempt_in = '0;
                  FUNC_BUSY:  busy_latched_in = 1'b1;
                  FUNC_REQUEST: begin
                     rsp_data_in.attempt_index = attempt_ff;
                     if (busy_latched_ff) begin
                        busy_latched_in         = 1'b0;
                        rsp_strobe_in           = 1'b1;
                        rsp_data_in.delay_ms    = {1'b0, busy_delay_ff};
                        rsp_data_in.from_busy   = 1'b1;
                     end else begin
                        // Start from base, clamped when base already tops cap.
                        dbl_in     = (base_ff > cap_ff) ? cap_ff : base_ff;
                        clamped_in = 1'b0;
                        remain_in  = attempt_ff;
                        mod_start  = 1'b1;
                        state_in   = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (!dbl_done) begin
               if (dbl_shift > {1'b0, cap_ff}) begin
                  dbl_in     = cap_ff;
                  clamped_in = 1'b1;
               end else begin
                  dbl_in    = dbl_shift[DELAY_BITS-1:0];
                  remain_in = remain_ff - ATTEMPT_BITS'(1);
               end
            end else if (mod_done) begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.delay_ms  = {1'b0, dbl_ff} + DELAY_OUT_BITS'(mod_rem);
               rsp_data_in.from_busy = 1'b0;
               if (attempt_ff != ATTEMPT_MAX) begin
                  attempt_in = attempt_ff + ATTEMPT_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         attempt_ff      <= '0;
         busy_latched_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         clamped_ff      <= 1'b0;
         remain_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         attempt_ff      <= attempt_in;
         busy_latched_ff <= busy_latched_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         clamped_ff      <= clamped_in;
         remain_ff       <= remain_in;
      end
      dbl_ff      <= dbl_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff == ST_RUN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A response comes only from a finished run or from an accepted command.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_RUN || accept))
      else $error("response without a transaction behind it");

   // The attempt counter holds still while a backoff run is in progress.
   a_attempt_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> $stable(attempt_ff))
      else $error("attempt counter moved during a run");

   // A busy answer leaves the counter alone.
   a_busy_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.from_busy |-> attempt_ff == rsp_data_ff.attempt_index)
      else $error("busy answer changed the attempt counter");

   // A backoff answer advances the counter by one, saturating.
   a_backoff_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_data_ff.from_busy |->
         (attempt_ff == rsp_data_ff.attempt_index + ATTEMPT_BITS'(1)) ||
         (rsp_data_ff.attempt_index == ATTEMPT_MAX && attempt_ff == ATTEMPT_MAX))
      else $error("attempt counter did not advance after a backoff answer");

endmodule
